[rtl/cmy_ed_pkg.sv]
package cmy_ed_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int NUM_CH   = 3;
  localparam int PIX_W    = 8;
  localparam int ERR_W    = 10;
  localparam int IN_W     = NUM_CH * PIX_W;
  localparam int OUT_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int CFG_W    = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd500;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd375;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic signed [ERR_W-1:0] err_t;

  // Position flags of one pixel, computed at input transfer time
  typedef struct packed {
    logic odd;
    logic has_left;
    logic has_right;
    logic last_row;
    logic frame_end;
  } pix_ctl_t;

endpackage

[rtl/cmy_ed_ram.sv]
module cmy_ed_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/cmy_ed_pos.sv]
module cmy_ed_pos
  import cmy_ed_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int XW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WIDTH_W-1:0]  image_width,
  input  logic [HEIGHT_W-1:0] image_height,
  input  logic                advance,
  output logic [XW-1:0]       x,
  output pix_ctl_t            ctl
);

  localparam int WCW = (XW + 1 > WIDTH_W) ? XW + 1 : WIDTH_W;

  logic [XW-1:0]    col_r, col_nxt, col, wl;
  logic [ROW_W-1:0] row_r, row_nxt, row, hl;
  logic [WCW-1:0]   w_ext;
  logic             last_col, last_row;

  assign w_ext = WCW'(image_width);

  // Last column and last row indexes, with the size registers clamped
  always_comb begin
    if (image_width == '0) begin
      wl = '0;
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      wl = XW'(MAX_WIDTH - 1);
    end else begin
      wl = XW'(w_ext - WCW'(1));
    end
    if (image_height == '0) begin
      hl = '0;
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      hl = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hl = ROW_W'(image_height - HEIGHT_W'(1));
    end
  end

  assign col      = (col_r > wl) ? wl : col_r;
  assign row      = (row_r > hl) ? hl : row_r;
  assign last_col = (col == wl);
  assign last_row = (row == hl);
  assign x        = row[0] ? (wl - col) : col;

  assign ctl.odd       = row[0];
  assign ctl.has_left  = (x != '0);
  assign ctl.has_right = (x != wl);
  assign ctl.last_row  = last_row;
  assign ctl.frame_end = last_col && last_row;

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row + ROW_W'(1);
    end else begin
      col_nxt = col + XW'(1);
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[rtl/cmy_ed_diffuse.sv]
module cmy_ed_diffuse
  import cmy_ed_pkg::*;
(
  input  logic [PIX_W-1:0] sample,
  input  err_t             ahead_in,
  input  err_t             cur_err,
  input  err_t             old_l,
  input  err_t             old_c,
  input  err_t             old_r,
  input  logic             odd,
  input  logic             has_ahead,
  output logic             on,
  output err_t             ahead_out,
  output err_t             new_l,
  output err_t             new_c,
  output err_t             new_r
);

  localparam int SUM_W = 12;
  localparam int MUL_W = 16;

  function automatic logic signed [MUL_W-1:0] ext(input err_t a);
    return {{(MUL_W - ERR_W){a[ERR_W-1]}}, a};
  endfunction

  // Divide by 16 rounding toward zero
  function automatic logic signed [MUL_W-1:0] div16_tz(input logic signed [MUL_W-1:0] a);
    logic signed [MUL_W-1:0] mag;
    mag = -a;
    return a[MUL_W-1] ? -(mag >>> 4) : (a >>> 4);
  endfunction

  function automatic err_t sat_err(input logic signed [MUL_W-1:0] a);
    if (a < -16'sd512) begin
      return err_t'(10'h200);
    end else if (a > 16'sd511) begin
      return err_t'(10'h1ff);
    end
    return a[ERR_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] v, e;
  logic signed [MUL_W-1:0] e16, m3, m5, m7, s1, s3, s5, s7;

  // Invert to CMY and add the pending errors
  assign v = $signed({4'b0000, ~sample})
           + {{(SUM_W - ERR_W){ahead_in[ERR_W-1]}}, ahead_in}
           + {{(SUM_W - ERR_W){cur_err[ERR_W-1]}}, cur_err};

  assign on  = (v < 12'sd128);
  assign e   = on ? v : v - 12'sd255;
  assign e16 = {{(MUL_W - SUM_W){e[SUM_W-1]}}, e};

  assign m3 = (e16 <<< 1) + e16;
  assign m5 = (e16 <<< 2) + e16;
  assign m7 = (e16 <<< 3) - e16;

  assign s1 = div16_tz(e16);
  assign s3 = div16_tz(m3);
  assign s5 = div16_tz(m5);
  assign s7 = div16_tz(m7);

  assign ahead_out = has_ahead ? sat_err(s7) : '0;
  assign new_c     = sat_err(ext(old_c) + s5);
  // Ahead-below takes 1/16, behind-below 3/16; direction flips on odd rows
  assign new_l     = sat_err(ext(old_l) + (odd ? s1 : s3));
  assign new_r     = sat_err(ext(old_r) + (odd ? s3 : s1));

endmodule

[rtl/cmy_serpentine_error_diffusion_top.sv]
// An accepted pixel passes the input register and then, once it is free, the result register before out_tvalid rises.
// Throughput: one pixel per cycle while out_tready allows; each error line is split into four column banks so the
// three next-row updates and the current-row read/clear each use their own RAM port.
// Reset (synchronous, rst_n low): size registers return to 500 x 375, position and errors
// clear, then a clearing pass over all ceil(MAX_WIDTH/4) addresses of each bank (256 by default) zeroes the
// error lines with in_tready held low; configuration writes are taken throughout.
module cmy_serpentine_error_diffusion_top
  import cmy_ed_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  // Pixel input
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Halftone output
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // red_on [0], green_on [1], blue_on [2], zero [7:3]
  output logic             out_tlast,  // last pixel of the frame
  // Configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = (MAX_WIDTH + 3) / 4;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RAM_W = NUM_CH * ERR_W;
  localparam int NRAM  = 8;  // two error lines times four column banks

  function automatic logic [1:0] bank_of(input logic [XW-1:0] p);
    return 2'(p);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] p);
    return AW'(p >> 2);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers; unchecked here, the user must let writes land only while the block is idle
  // ---------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and clearing pass
  // ---------------------------------------------------------------------
  logic          clr_done_r;
  logic [AW-1:0] clr_cnt_r;
  logic          s1_vld_r;
  logic          out_vld_r;
  logic          s1_fire;
  logic          accept;

  // The result register frees up when empty or when its transfer completes
  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = clr_done_r && (!s1_vld_r || s1_fire);
  assign accept    = in_tvalid && in_tready;

  // Sweep every bank address once after reset, writing zero to all RAMs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: pixel position and RAM read addresses
  // ---------------------------------------------------------------------
  logic [XW-1:0] x0, pl0, pr0;
  pix_ctl_t      ctl0;

  cmy_ed_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .advance      (accept),
    .x            (x0),
    .ctl          (ctl0)
  );

  assign pl0 = x0 - XW'(1);
  assign pr0 = x0 + XW'(1);

  logic [AW-1:0]    rd_addr [NRAM];
  logic [AW-1:0]    wr_addr [NRAM];
  logic [RAM_W-1:0] wr_data [NRAM];
  logic [RAM_W-1:0] ram_q   [NRAM];
  logic [RAM_W-1:0] rdq     [NRAM];
  logic             wr_en   [NRAM];

  // Current line: read the pixel's own entry. Next line: read the pixel's
  // entry and its two neighbors, each in a bank of its own.
  always_comb begin
    for (int k = 0; k < NRAM; k++) begin
      rd_addr[k] = addr_of(x0);
      if (1'(k >> 2) != ctl0.odd) begin
        if (bank_of(pl0) == 2'(k) && ctl0.has_left) begin
          rd_addr[k] = addr_of(pl0);
        end else if (bank_of(pr0) == 2'(k) && ctl0.has_right) begin
          rd_addr[k] = addr_of(pr0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register, error arithmetic, RAM writes
  // ---------------------------------------------------------------------
  logic [IN_W-1:0] s1_rgb_r;
  logic [XW-1:0]   s1_x_r, pl1, pr1;
  pix_ctl_t        s1_ctl_r;
  logic            byp_hit_r  [NRAM];
  logic [RAM_W-1:0] byp_data_r [NRAM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  // Hold the pixel and catch any write that lands on an address being read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rgb_r <= in_tdata;
      s1_x_r   <= x0;
      s1_ctl_r <= ctl0;
      for (int k = 0; k < NRAM; k++) begin
        byp_hit_r[k]  <= wr_en[k] && (wr_addr[k] == rd_addr[k]);
        byp_data_r[k] <= wr_data[k];
      end
    end
  end

  assign pl1 = s1_x_r - XW'(1);
  assign pr1 = s1_x_r + XW'(1);

  for (genvar k = 0; k < NRAM; k++) begin : g_ram
    cmy_ed_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[k]),
      .wr_addr (wr_addr[k]),
      .wr_data (wr_data[k]),
      .rd_en   (accept),
      .rd_addr (rd_addr[k]),
      .rd_data (ram_q[k])
    );
    assign rdq[k] = byp_hit_r[k] ? byp_data_r[k] : ram_q[k];
  end

  logic             has_ahead1, col0_1;
  logic [RAM_W-1:0] cur_pk, l_pk, c_pk, r_pk;
  logic [RAM_W-1:0] new_l_pk, new_c_pk, new_r_pk;
  logic [NUM_CH-1:0] on;
  err_t             ahead_r   [NUM_CH];
  err_t             ahead_in  [NUM_CH];
  err_t             ahead_out [NUM_CH];

  assign has_ahead1 = s1_ctl_r.odd ? s1_ctl_r.has_left  : s1_ctl_r.has_right;
  assign col0_1     = !(s1_ctl_r.odd ? s1_ctl_r.has_right : s1_ctl_r.has_left);

  assign cur_pk = rdq[{s1_ctl_r.odd, bank_of(s1_x_r)}];
  assign l_pk   = rdq[{!s1_ctl_r.odd, bank_of(pl1)}];
  assign c_pk   = rdq[{!s1_ctl_r.odd, bank_of(s1_x_r)}];
  assign r_pk   = rdq[{!s1_ctl_r.odd, bank_of(pr1)}];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    err_t nl, nc, nr;

    // Drop the carried error at the start of a row
    assign ahead_in[ch] = col0_1 ? '0 : ahead_r[ch];

    cmy_ed_diffuse u_diffuse (
      .sample    (s1_rgb_r[ch*PIX_W +: PIX_W]),
      .ahead_in  (ahead_in[ch]),
      .cur_err   (err_t'(cur_pk[ch*ERR_W +: ERR_W])),
      .old_l     (err_t'(l_pk[ch*ERR_W +: ERR_W])),
      .old_c     (err_t'(c_pk[ch*ERR_W +: ERR_W])),
      .old_r     (err_t'(r_pk[ch*ERR_W +: ERR_W])),
      .odd       (s1_ctl_r.odd),
      .has_ahead (has_ahead1),
      .on        (on[ch]),
      .ahead_out (ahead_out[ch]),
      .new_l     (nl),
      .new_c     (nc),
      .new_r     (nr)
    );

    assign new_l_pk[ch*ERR_W +: ERR_W] = nl;
    assign new_c_pk[ch*ERR_W +: ERR_W] = nc;
    assign new_r_pk[ch*ERR_W +: ERR_W] = nr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        ahead_r[ch] <= '0;
      end
    end else if (s1_fire) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        ahead_r[ch] <= ahead_out[ch];
      end
    end
  end

  // Clear the consumed entry of the current line; on all but the last row, write back the
  // updated entries of the next line (own column and each neighbor that exists); zero all RAMs while clearing
  always_comb begin
    for (int k = 0; k < NRAM; k++) begin
      wr_en[k]   = 1'b0;
      wr_addr[k] = addr_of(s1_x_r);
      wr_data[k] = '0;
      if (!clr_done_r) begin
        wr_en[k]   = 1'b1;
        wr_addr[k] = clr_cnt_r;
      end else if (1'(k >> 2) == s1_ctl_r.odd) begin
        wr_en[k] = s1_fire && (bank_of(s1_x_r) == 2'(k));
      end else if (bank_of(s1_x_r) == 2'(k)) begin
        wr_en[k]   = s1_fire && !s1_ctl_r.last_row;
        wr_data[k] = new_c_pk;
      end else if (bank_of(pl1) == 2'(k) && s1_ctl_r.has_left) begin
        wr_en[k]   = s1_fire && !s1_ctl_r.last_row;
        wr_addr[k] = addr_of(pl1);
        wr_data[k] = new_l_pk;
      end else if (bank_of(pr1) == 2'(k) && s1_ctl_r.has_right) begin
        wr_en[k]   = s1_fire && !s1_ctl_r.last_row;
        wr_addr[k] = addr_of(pr1);
        wr_data[k] = new_r_pk;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [NUM_CH-1:0] out_on_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_on_r   <= on;
      out_last_r <= s1_ctl_r.frame_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_W - NUM_CH)'(0), out_on_r};
  assign out_tlast  = out_last_r;

endmodule

[test/tb_cmy_serpentine_error_diffusion_top.sv]
`timescale 1ns / 1ps

module tb_cmy_serpentine_error_diffusion_top;
  import cmy_ed_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PRINT_LIMIT  = 40;

  // One RGB pixel, packed as it travels on in_tdata (red in the low byte)
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // One halftone decision as it comes back on out_tdata / out_tlast
  typedef struct {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic frame_end;
  } halftone_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // red [7:0], green [15:8], blue [23:16]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // red_on [0], green_on [1], blue_on [2], zero [7:3]
  logic             out_tlast;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index  = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data   = '0;

  // Shadow of the size registers and of the diffusion state
  logic [WIDTH_W-1:0]  size_width  = WIDTH_RST;
  logic [HEIGHT_W-1:0] size_height = HEIGHT_RST;
  err_t                line_err [2*MAX_W][NUM_CH] = '{default: '0};
  err_t                ahead_err [NUM_CH] = '{default: '0};
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  halftone_t pending_halftones [$];
  int        fail_count   = 0;
  int        pixels_sent  = 0;
  int        results_seen = 0;

  // Idle shaping: a calm side never inserts gaps
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;

  cmy_serpentine_error_diffusion_top #(
    .MAX_WIDTH (MAX_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run, reset clearing pass included
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp a running error into the stored signed 10-bit range
  function automatic err_t clamp_err(input int v);
    if (v < -512) return err_t'(-512);
    if (v > 511) return err_t'(511);
    return err_t'(v);
  endfunction

  // Accumulate one share into the next-row error line
  function automatic void add_line_share(input int line, input int x, input int ch,
                                         input int share);
    line_err[line*MAX_W + x][ch] = clamp_err(int'(line_err[line*MAX_W + x][ch]) + share);
  endfunction

  // Effective sizes: zero acts as one, oversize acts as the maximum
  function automatic int eff_width();
    if (size_width < 1) return 1;
    if (size_width > MAX_W) return MAX_W;
    return int'(size_width);
  endfunction

  function automatic int eff_height();
    if (size_height < 1) return 1;
    if (size_height > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(size_height);
  endfunction

  // Halftone one pixel and advance the shadow state
  function automatic halftone_t predict_halftone(input pixel_t px);
    halftone_t        res;
    logic [IN_W-1:0]  bits;
    logic [NUM_CH-1:0] on;
    int  w, h, col, row, x, cur, nxt, v, e, ax, bx;
    bit  odd, last_col, last_row, has_ahead, has_behind;
    bits = px;
    w = eff_width();
    h = eff_height();
    // Counters left past the bounds by a size change snap to the last column/row
    col = (col_pos < w) ? int'(col_pos) : w - 1;
    row = (row_pos < h) ? int'(row_pos) : h - 1;
    odd      = row[0];
    x        = odd ? (w - 1 - col) : col;
    last_col = (col == w - 1);
    last_row = (row == h - 1);
    cur      = row & 1;
    nxt      = cur ^ 1;

    // Nothing carries across a row boundary
    if (col == 0) begin
      foreach (ahead_err[c]) ahead_err[c] = '0;
    end

    for (int c = 0; c < NUM_CH; c++) begin
      v = 255 - int'(bits[c*PIX_W +: PIX_W]) + int'(ahead_err[c])
          + int'(line_err[cur*MAX_W + x][c]);
      line_err[cur*MAX_W + x][c] = '0;
      if (v >= 128) begin
        e     = v - 255;
        on[c] = 1'b0;
      end else begin
        e     = v;
        on[c] = 1'b1;
      end

      // Ahead follows the scan direction of the row
      if (odd) begin
        has_ahead  = (x > 0);
        has_behind = (x + 1 < w);
        ax         = has_ahead ? x - 1 : 0;
        bx         = x + 1;
      end else begin
        has_ahead  = (x + 1 < w);
        has_behind = (x > 0);
        ax         = x + 1;
        bx         = has_behind ? x - 1 : 0;
      end

      ahead_err[c] = has_ahead ? clamp_err((7 * e) / 16) : err_t'(0);
      if (!last_row) begin
        add_line_share(nxt, x, c, (5 * e) / 16);
        if (has_ahead)  add_line_share(nxt, ax, c, e / 16);
        if (has_behind) add_line_share(nxt, bx, c, (3 * e) / 16);
      end
    end

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end

    res.red_on    = on[0];
    res.green_on  = on[1];
    res.blue_on   = on[2];
    res.frame_end = last_col && last_row;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pixel_t make_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red   = PIX_W'(r);
    px.green = PIX_W'(g);
    px.blue  = PIX_W'(b);
    return px;
  endfunction

  // Favor the rails and the threshold neighborhood, otherwise uniform
  function automatic logic [PIX_W-1:0] random_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(120, 135));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Send one pixel; enter and leave at a falling edge. Valid stays high on
  // return so back-to-back pixels keep it asserted.
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    pending_halftones.push_back(predict_halftone(px));
    pixels_sent++;
    @(negedge clk);
  endtask

  // Write one size register; only called while the block is idle
  task automatic write_size_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == CFG_IMAGE_WIDTH) size_width = value[WIDTH_W-1:0];
    else size_height = value[HEIGHT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_halftones.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver backpressure: hold ready low for a picked stall, else accept
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) rx_hold = pick_gap(1'b0);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int idx, input logic exp_bit,
                             input logic got_bit);
    if (got_bit !== exp_bit)
      report_fail($sformatf("result %0d %s: expected %0b got %0b", idx, name, exp_bit,
                            got_bit));
  endtask

  // Compare each output transfer with the oldest pending halftone
  always @(posedge clk) begin : check_results
    halftone_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_halftones.size() == 0) begin
        report_fail($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_halftones.pop_front();
        check_field("red_on",    results_seen, want.red_on,    out_tdata[0]);
        check_field("green_on",  results_seen, want.green_on,  out_tdata[1]);
        check_field("blue_on",   results_seen, want.blue_on,   out_tdata[2]);
        check_field("pad",       results_seen, 1'b0,           |out_tdata[OUT_W-1:3]);
        check_field("frame_end", results_seen, want.frame_end, out_tlast);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default 500 x 375: rails and both sides of the threshold
  task automatic test_default_size();
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(127, 128, 127));
    send_pixel(make_pixel(128, 127, 128));
    send_pixel(make_pixel(255, 0, 170));
  endtask

  // Shrink the width mid-row: the column snaps to the last one, then an odd row
  task automatic test_width_shrink();
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(4));
    send_pixel(make_pixel(10, 200, 128));
    repeat (4) send_pixel(make_pixel(100, 140, 60));
  endtask

  // Zero width and zero height act as one, so every such pixel ends a frame; then a 2 x 1 frame
  task automatic test_min_sizes();
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(0));
    write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'(0));
    send_pixel(make_pixel(127, 127, 127));
    send_pixel(make_pixel(0, 255, 128));
    send_pixel(make_pixel(255, 0, 127));
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
    write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
    send_pixel(make_pixel(64, 192, 32));
    send_pixel(make_pixel(200, 50, 130));
  endtask

  // Oversize width and height clamp to the maximum; reach the far column on
  // an odd row by stepping past row 0 at width one first
  task automatic test_max_sizes();
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(0));
    write_size_reg(CFG_IMAGE_HEIGHT, '1);
    send_pixel(make_pixel(0, 0, 0));
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(2047));
    send_pixel(make_pixel(255, 255, 255));
    send_pixel(make_pixel(128, 128, 128));
    send_pixel(make_pixel(127, 1, 254));
  endtask

  // Shrink the height below the current row: that row becomes the last one
  task automatic test_height_shrink();
    settle_idle();
    write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
    write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'(5));
    repeat (6) send_pixel(make_pixel(random_level(), random_level(), random_level()));
    settle_idle();
    write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
    send_pixel(make_pixel(90, 160, 30));
    send_pixel(make_pixel(30, 90, 160));
  endtask

  // Phases of random sizes; most finish whole frames, some stop mid-frame
  task automatic test_random_frames();
    int target, w, h, col, row, count, roll;
    target = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < target) begin
      settle_idle();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // Wide, partial row: a 13-bit write of 1000 or more, upper bits ignored by the register
        write_size_reg(CFG_IMAGE_WIDTH, CFG_W'($urandom_range(1000, 8191)));
        write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 3)));
        count = $urandom_range(5, 40);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          roll = $urandom_range(0, 99);
          if (roll < 75)      w = $urandom_range(2, 9);
          else if (roll < 90) w = $urandom_range(10, 40);
          else if (roll < 95) w = $urandom_range(0, 1);
          else                w = $urandom_range(41, 120);
          write_size_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        end
        if (roll >= 50 || $urandom_range(0, 1) == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 70)      h = $urandom_range(1, 6);
          else if (roll < 85) h = $urandom_range(7, 20);
          else begin
            case ($urandom_range(0, 3))
              0:       h = 0;
              1:       h = MAX_HEIGHT;
              2:       h = 8191;
              default: h = $urandom_range(0, 8191);
            endcase
          end
          write_size_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        end
        w   = eff_width();
        h   = eff_height();
        col = (col_pos < w) ? int'(col_pos) : w - 1;
        row = (row_pos < h) ? int'(row_pos) : h - 1;
        if ($urandom_range(0, 9) < 7)
          count = (w - col) + (h - 1 - row) * w + $urandom_range(0, 2) * w * h;
        else
          count = $urandom_range(1, 2 * w);
        if (count > 300) count = 300;
      end
      // Stop at the item budget
      if (count > target - pixels_sent) count = target - pixels_sent;
      repeat (count) send_pixel(make_pixel(random_level(), random_level(), random_level()));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset low, then release it; the block then runs its clearing pass with
    // in_tready low, which the pixel handshake simply waits out
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_size();
    test_width_shrink();
    test_min_sizes();
    test_max_sizes();
    test_height_shrink();
    test_random_frames();

    settle_idle();
    repeat (10) @(negedge clk);
    if (pending_halftones.size() != 0)
      report_fail($sformatf("%0d results never arrived", pending_halftones.size()));

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
